>>> design/message_dedup_filter_assert.svh
// Assertion macros shared by the message_dedup_filter RTL.
`ifndef MESSAGE_DEDUP_FILTER_ASSERT_SVH
`define MESSAGE_DEDUP_FILTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked only while out of reset.
`define MDF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("mdf assertion failed");

// Checked at every edge, reset included.
`define MDF_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("mdf assertion failed");

`else

`define MDF_ASSERT(lbl, prop)
`define MDF_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

>>> design/mdf_pkg.sv
package mdf_pkg;

    localparam int WORD_W      = 64;
    localparam int KEY_W       = 5 * WORD_W;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic load_key;
        logic search_start;
        logic search_step;
        logic insert;
    } t_dp_cmd;

    typedef struct packed {
        logic match;
        logic done;
    } t_dp_sts;

endpackage

>>> design/mdf_datapath.sv
`include "message_dedup_filter_assert.svh"

module mdf_datapath #(
    parameter int SEEN_DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [mdf_pkg::KEY_W-1:0] i_key,
    input  mdf_pkg::t_dp_cmd         i_cmd,
    output mdf_pkg::t_dp_sts         o_sts
);

    localparam int IDX_W = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
    localparam int CNT_W = $clog2(SEEN_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(SEEN_DEPTH);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(SEEN_DEPTH - 1);

    logic [mdf_pkg::KEY_W-1:0] r_mem [SEEN_DEPTH];
    logic [mdf_pkg::KEY_W-1:0] r_key;
    logic [mdf_pkg::KEY_W-1:0] r_rd_data;

    logic [CNT_W-1:0] r_idx,    n_idx;
    logic             r_pend,   n_pend;
    logic [CNT_W-1:0] r_fill,   n_fill;
    logic [IDX_W-1:0] r_oldest, n_oldest;

    logic             rd_en;
    logic             full;
    logic [IDX_W-1:0] wr_slot;

    assign full  = (r_fill == FULL);
    assign rd_en = i_cmd.search_step && (r_idx < r_fill);

    always_comb begin
        n_idx    = r_idx;
        n_pend   = r_pend;
        n_fill   = r_fill;
        n_oldest = r_oldest;
        wr_slot  = full ? r_oldest : r_fill[IDX_W-1:0];
        if (i_cmd.search_start) begin
            n_idx  = '0;
            n_pend = 1'b0;
        end else if (i_cmd.search_step) begin
            n_pend = rd_en;
            if (rd_en) begin
                n_idx = r_idx + CNT_W'(1);
            end
        end
        if (i_cmd.insert) begin
            if (!full) begin
                n_fill = r_fill + CNT_W'(1);
            end else begin
                n_oldest = (r_oldest == LAST) ? '0 : r_oldest + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_pend   <= 1'b0;
            r_fill   <= '0;
            r_oldest <= '0;
        end else begin
            r_idx    <= n_idx;
            r_pend   <= n_pend;
            r_fill   <= n_fill;
            r_oldest <= n_oldest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_key) begin
            r_key <= i_key;
        end
    end

    // key store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            r_mem[wr_slot] <= r_key;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx[IDX_W-1:0]];
        end
    end

    assign o_sts.match = r_pend && (r_rd_data == r_key);
    assign o_sts.done  = !r_pend && !(r_idx < r_fill);

    `MDF_ASSERT_ALWAYS(a_fill_bound, !i_rst_n || (r_fill <= FULL))
    `MDF_ASSERT(a_oldest_idle, !full |-> (r_oldest == '0))
    `MDF_ASSERT(a_fill_inc, (i_cmd.insert && !full) |=> (r_fill == $past(r_fill) + CNT_W'(1)))

endmodule

>>> design/mdf_ctrl.sv
`include "message_dedup_filter_assert.svh"

module mdf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output logic              o_out_is_new,
    input  logic              i_out_ready,
    output mdf_pkg::t_dp_cmd  o_cmd,
    input  mdf_pkg::t_dp_sts  i_sts
);

    mdf_pkg::t_state r_state, n_state;
    logic            r_is_new, n_is_new;
    logic            r_out_valid, n_out_valid;
    logic            r_out_is_new, n_out_is_new;
    logic            out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mdf_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_new     <= n_is_new;
        r_out_is_new <= n_out_is_new;
    end

    always_comb begin
        n_state      = r_state;
        n_is_new     = r_is_new;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_is_new = r_out_is_new;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            mdf_pkg::S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load_key     = 1'b1;
                    o_cmd.search_start = 1'b1;
                    n_state            = mdf_pkg::S_SEARCH;
                end
            end
            mdf_pkg::S_SEARCH: begin
                o_cmd.search_step = 1'b1;
                if (i_sts.match) begin
                    n_is_new = 1'b0;
                    n_state  = mdf_pkg::S_RESULT;
                end else if (i_sts.done) begin
                    o_cmd.insert = 1'b1;
                    n_is_new     = 1'b1;
                    n_state      = mdf_pkg::S_RESULT;
                end
            end
            mdf_pkg::S_RESULT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_is_new = r_is_new;
                    n_state      = mdf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mdf_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_is_new = r_out_is_new;

    `MDF_ASSERT(a_insert_in_search, o_cmd.insert |-> (r_state == mdf_pkg::S_SEARCH))
    `MDF_ASSERT(a_accept_starts, (i_in_valid && o_in_ready) |=> (r_state == mdf_pkg::S_SEARCH))
    `MDF_ASSERT(a_result_loads, (r_state == mdf_pkg::S_RESULT && out_free) |=> r_out_valid)

endmodule

>>> design/message_dedup_filter.sv
// Channel   Dir  tdata bits  Contents
// s_axis    in   320         origin_word0..3, sequence_number
// m_axis    out  8           is_new, zero fill
//
// A new key is compared with every stored key and then inserted; a duplicate found
// in slot j ends the search at that slot.
// The search reads one stored key per cycle.
// One item is in work at a time; a finished result waits in the output
// register, and the next item is taken while it waits.
// Synchronous active-low reset empties the store at once (fill count zero).
`include "message_dedup_filter_assert.svh"

module message_dedup_filter #(
    parameter int SEEN_DEPTH = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // origin_word0, origin_word1, origin_word2, origin_word3, sequence_number
    input  logic [mdf_pkg::KEY_W-1:0]        s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // is_new, then seven zero bits
    output logic [mdf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    mdf_pkg::t_dp_cmd cmd;
    mdf_pkg::t_dp_sts sts;
    logic             out_is_new;

    mdf_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_is_new (out_is_new),
        .i_out_ready  (m_axis_tready),
        .o_cmd        (cmd),
        .i_sts        (sts)
    );

    mdf_datapath #(
        .SEEN_DEPTH (SEEN_DEPTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (s_axis_tdata),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

    assign m_axis_tdata = {{(mdf_pkg::OUT_TDATA_W - 1){1'b0}}, out_is_new};

    `MDF_ASSERT(a_no_accept_busy, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    `MDF_ASSERT(a_match_excl, !(sts.match && sts.done))
    `MDF_ASSERT_ALWAYS(a_out_pad, m_axis_tdata[mdf_pkg::OUT_TDATA_W-1:1] == '0)

endmodule

>>> verif/tb_message_dedup_filter.sv
module tb_message_dedup_filter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH     = 256;
    localparam int STALL_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 300;
    localparam int KEY_LOG_DEPTH  = 600;

    // w0 in the lowest bits, seq in the highest
    typedef struct packed {
        logic [mdf_pkg::WORD_W-1:0] seq;
        logic [mdf_pkg::WORD_W-1:0] w3;
        logic [mdf_pkg::WORD_W-1:0] w2;
        logic [mdf_pkg::WORD_W-1:0] w1;
        logic [mdf_pkg::WORD_W-1:0] w0;
    } t_msg_key;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // origin_word0, origin_word1, origin_word2, origin_word3, sequence_number
    logic [mdf_pkg::KEY_W-1:0]       s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b1;
    // is_new, then seven zero bits
    logic [mdf_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    message_dedup_filter #(
        .SEEN_DEPTH(RING_DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // seen-key ring mirror
    t_msg_key ring_keys [RING_DEPTH];
    int       ring_fill = 0;
    int       ring_oldest = 0;

    bit       expected_is_new [$];
    t_msg_key key_log [$];
    int       error_count = 0;
    int       idle_cycles = 0;
    bit       tx_idle_en = 1'b1;
    bit       rx_stall_en = 1'b1;
    int       rx_hold = 0;

    function automatic bit predict_is_new(t_msg_key k);
        int slot;
        for (int i = 0; i < ring_fill; i++) begin
            if (ring_keys[i] == k) begin
                return 1'b0;
            end
        end
        if (ring_fill < RING_DEPTH) begin
            slot = ring_fill;
            ring_fill++;
        end else begin
            slot = ring_oldest;
            ring_oldest = (ring_oldest + 1) % RING_DEPTH;
        end
        ring_keys[slot] = k;
        return 1'b1;
    endfunction

    function automatic logic [mdf_pkg::WORD_W-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic t_msg_key fresh_key();
        t_msg_key k;
        k = '{seq: rand64(), w3: rand64(), w2: rand64(), w1: rand64(), w0: rand64()};
        case ($urandom_range(0, 5))
            0: begin
                k.w2 = '0;
                k.w3 = '0;
            end
            1: begin
                k.w1 = '0;
                k.w2 = '0;
                k.w3 = '0;
            end
            2: begin
                if (key_log.size() != 0) begin
                    k.seq = key_log[$urandom_range(0, key_log.size() - 1)].seq;
                end
            end
            3: begin
                if (key_log.size() != 0) begin
                    k = key_log[key_log.size() - 1];
                    k.seq = k.seq + 1;
                end
            end
            4: begin
                k.seq = ($urandom_range(0, 1) != 0) ? '1 : '0;
            end
            default: begin
            end
        endcase
        return k;
    endfunction

    task automatic send_key(t_msg_key k);
        int gap;
        bit exp_new;
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= k;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        exp_new = predict_is_new(k);
        expected_is_new = {expected_is_new, exp_new};
        key_log = {key_log, k};
        if (key_log.size() > KEY_LOG_DEPTH) begin
            key_log.delete(0);
        end
    endtask

    task automatic test_directed_keys();
        t_msg_key k;
        k = '0;
        send_key(k);
        send_key(k);
        k = '1;
        send_key(k);
        send_key(k);
        for (int w = 0; w < 5; w++) begin
            k = '0;
            k[w*mdf_pkg::WORD_W +: mdf_pkg::WORD_W] = '1;
            send_key(k);
        end
        k = '0;
        k.seq = 64'd1;
        send_key(k);
        send_key(k);
        k = '0;
        k.w0 = 64'h8000_0000_0000_0000;
        send_key(k);
        k = '0;
        k.w0 = rand64();
        k.w1 = rand64();
        k.seq = '1;
        send_key(k);
        send_key(k);
        k.seq = k.seq - 1;
        send_key(k);
        k.w3 = 64'd1;
        send_key(k);
    endtask

    // mostly resends and near misses so the ring fills, wraps and evicts
    task automatic test_random_traffic(int n_items, bit allow_idle);
        t_msg_key k;
        int       pick;
        int       span;
        int       bit_idx;
        tx_idle_en  = allow_idle;
        rx_stall_en = allow_idle;
        for (int i = 0; i < n_items; i++) begin
            if (allow_idle && i % 100 == 0) begin
                tx_idle_en  = ($urandom_range(0, 3) != 0);
                rx_stall_en = ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 99);
            if (key_log.size() == 0 || pick < 40) begin
                k = fresh_key();
            end else if (pick < 75) begin
                span = (key_log.size() < 200) ? key_log.size() : 200;
                k = key_log[key_log.size() - 1 - $urandom_range(0, span - 1)];
            end else if (pick < 85) begin
                k = key_log[$urandom_range(0, key_log.size() - 1)];
            end else begin
                k = key_log[$urandom_range(0, key_log.size() - 1)];
                bit_idx = $urandom_range(0, mdf_pkg::KEY_W - 1);
                k[bit_idx] = ~k[bit_idx];
            end
            send_key(k);
        end
    endtask

    task automatic test_drain_pause();
        s_axis_tvalid <= 1'b0;
        while (expected_is_new.size() != 0) @(posedge i_clk);
        repeat (2) send_key(key_log[key_log.size() - 1]);
    endtask

    // receiver stalls: random bursts with m_axis_tready held low
    always @(posedge i_clk) begin
        if (rx_hold > 1) begin
            rx_hold <= rx_hold - 1;
        end else if (rx_hold == 1) begin
            rx_hold <= 0;
            m_axis_tready <= 1'b1;
        end else if (rx_stall_en && $urandom_range(0, 9) == 0) begin
            m_axis_tready <= 1'b0;
            rx_hold <= $urandom_range(1, 18);
        end
    end

    // result check and stall watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_is_new.size() == 0) begin
                    $error("unexpected result transfer: is_new %0d", m_axis_tdata[0]);
                    error_count++;
                end else begin
                    if (m_axis_tdata[0] !== expected_is_new[0]) begin
                        $error("is_new mismatch: expected %0d, actual %0d",
                               expected_is_new[0], m_axis_tdata[0]);
                        error_count++;
                    end
                    expected_is_new.delete(0);
                end
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= STALL_LIMIT) begin
                $display("tb_message_dedup_filter: done, errors");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_keys();
        test_random_traffic(500, 1'b1);
        test_drain_pause();
        test_random_traffic(550, 1'b1);
        test_random_traffic(150, 1'b0);
        s_axis_tvalid <= 1'b0;
        while (expected_is_new.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_message_dedup_filter: done, clean");
        end else begin
            $display("tb_message_dedup_filter: done, errors");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/mdf_pkg.sv
design/mdf_datapath.sv
design/mdf_ctrl.sv
design/message_dedup_filter.sv
verif/tb_message_dedup_filter.sv
